/* hw/rtl/pss_pkg.sv */
`default_nettype none
package pss_pkg;

  localparam int COORD_BITS    = 9;
  localparam int FRAC_BITS     = 8;

  typedef struct packed {
    logic [8:0] px;
    logic [8:0] py;
    logic       final_point;
  } pss_in_t;

  typedef struct packed {
    logic [16:0] sx;
    logic [16:0] sy;
    logic        final_result;
    logic        dropped;
  } pss_out_t;

  localparam logic [1:0] REG_DATA_WEIGHT    = 2'd0;
  localparam logic [1:0] REG_SMOOTH_WEIGHT  = 2'd1;
  localparam logic [1:0] REG_STOP_TOLERANCE = 2'd2;
  localparam logic [1:0] REG_SWEEP_LIMIT    = 2'd3;

  localparam int CFG_IDX_BITS  = 2;
  localparam int SUM_BITS      = 24;
  localparam int OUT_BITS      = 17;

  typedef struct packed {
    logic [7:0]  data_weight;
    logic [7:0]  smooth_weight;
    logic [15:0] stop_tolerance;
    logic [11:0] sweep_limit;
  } pss_cfg_t;

endpackage
`default_nettype wire

/* hw/rtl/path_simplify_and_smooth.sv */
`default_nettype none
// channel | handshake         | payload
// in      | start / busy      | in_data  (px, py, final_point)
// out     | out_strobe        | out_data (sx, sy, final_result, dropped)
// cfg     | cfg_valid / ready | cfg_index, cfg_data
// streaming points: one per cycle, busy stays low until the last point
// last point: store the pending point, copy the kept points, then per sweep
// for each interior point 3 reads, then multiply and write back per coordinate,
// plus a check, then emission, one result per cycle
// reset: synchronous active low; stores hold garbage until written
// results cannot be held off by the receiver
module path_simplify_and_smooth import pss_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire pss_in_t                 in_data,
  output logic                         out_strobe,
  output pss_out_t                     out_data,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [15:0]             cfg_data
);
  localparam int QB = COORD_BITS + FRAC_BITS;
  localparam int AB = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CB = $clog2(MAX_POINTS + 1);
  localparam int XB = 2*COORD_BITS + 3;

  localparam logic [2:0] S_IN = 3'd0, S_COPY = 3'd1, S_RD = 3'd2, S_MUL = 3'd3,
                         S_WB = 3'd4, S_CHK = 3'd5, S_EMIT = 3'd6, S_FIN = 3'd7;

  pss_cfg_t cfg_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_weight <= 8'd128; cfg_r.smooth_weight <= 8'd26;
      cfg_r.stop_tolerance <= 16'd1; cfg_r.sweep_limit <= 12'd1024;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DATA_WEIGHT:    cfg_r.data_weight    <= cfg_data[7:0];
        REG_SMOOTH_WEIGHT:  cfg_r.smooth_weight  <= cfg_data[7:0];
        REG_STOP_TOLERANCE: cfg_r.stop_tolerance <= cfg_data;
        REG_SWEEP_LIMIT:    cfg_r.sweep_limit    <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // memories: original points and smoothed points, {x,y}
  logic [2*COORD_BITS-1:0] kept_mem [MAX_POINTS];
  logic [2*QB-1:0]         sm_mem   [MAX_POINTS];

  logic [2:0] state_r;
  logic [1:0] phase_r;
  logic signed [COORD_BITS:0] anc_x_r, anc_y_r, bas_x_r, bas_y_r;
  logic [COORD_BITS-1:0] pend_x_r, pend_y_r;
  logic [CB-1:0] cnt_r;
  logic ovf_r;
  logic [AB-1:0] idx_r;
  logic [1:0] sub_r;   // read step: 0 prev, 1 cur, 2 next
  logic [11:0] sweep_r;
  logic [SUM_BITS-1:0] sum_r;
  logic [2*QB-1:0] prev_r, cur_r, rd_q;
  logic [2*COORD_BITS-1:0] kq;
  logic [2*QB-1:0] nxt_r;

  wire acc = start && !busy;
  assign busy = (state_r != S_IN);

  logic [COORD_BITS-1:0] ix, iy;
  logic signed [COORD_BITS:0] dx, dy;
  logic signed [XB-1:0] cr;
  logic kw_en;
  logic [COORD_BITS-1:0] kw_x, kw_y;
  logic [CB-1:0] cnt_a;
  logic ovf_a;
  always_comb begin
    ix = in_data.px[COORD_BITS-1:0]; iy = in_data.py[COORD_BITS-1:0];
    dx = $signed({1'b0, ix}) - anc_x_r;
    dy = $signed({1'b0, iy}) - anc_y_r;
    cr = XB'(bas_x_r) * XB'(dy) - XB'(dx) * XB'(bas_y_r);
  end

  // the last point of the path is kept in S_FIN, from the pending point
  always_comb begin
    kw_en = 1'b0; kw_x = ix; kw_y = iy;
    if (acc) begin
      if (phase_r == 2'd0) kw_en = 1'b1;
      else if (phase_r == 2'd2 && cr != 0) begin
        kw_en = 1'b1; kw_x = pend_x_r; kw_y = pend_y_r;
      end
    end
  end

  logic [CB-1:0] n_lim;
  assign n_lim = CB'(MAX_POINTS);
  logic [QB-1:0] up_new;
  logic [QB:0] up_diff;
  logic c_r; // coordinate: 0 x, 1 y

  logic [QB-1:0] o_c, p_c, q_c, n_c;
  always_comb begin
    o_c = c_r ? cur_r[QB-1:0] : cur_r[2*QB-1:QB];
    p_c = c_r ? prev_r[QB-1:0] : prev_r[2*QB-1:QB];
    n_c = c_r ? nxt_r[QB-1:0] : nxt_r[2*QB-1:QB];
    q_c = c_r ? {kq[COORD_BITS-1:0], FRAC_BITS'(0)}
              : {kq[2*COORD_BITS-1:COORD_BITS], FRAC_BITS'(0)};
  end

  pss_update #(.QB(QB)) u_upd (
    .clk(clk), .wd(cfg_r.data_weight), .ws(cfg_r.smooth_weight),
    .old_v(o_c), .orig_v(q_c), .prev_v(p_c), .next_v(n_c),
    .new_v(up_new), .diff_v(up_diff)
  );

  logic [AB-1:0] rd_a;
  logic [SUM_BITS:0] sum_w;
  logic [11:0] lim;
  assign lim = (cfg_r.sweep_limit == 0) ? 12'd1 : cfg_r.sweep_limit;
  assign sum_w = {1'b0, sum_r} + (SUM_BITS+1)'(up_diff);

  // original point store follows the current index only
  always_ff @(posedge clk) begin
    rd_q <= sm_mem[rd_a];
    kq   <= kept_mem[idx_r];
  end

  logic [2*QB-1:0] cur_upd;
  always_comb begin
    cur_upd = cur_r;
    if (c_r) cur_upd[QB-1:0] = up_new; else cur_upd[2*QB-1:QB] = up_new;
  end

  // emission reads one entry ahead so a beat leaves every cycle
  always_comb begin
    rd_a = idx_r;
    if (state_r == S_RD) rd_a = idx_r + AB'(sub_r) - AB'(1);
    else if (state_r == S_EMIT && sub_r != 2'd0) rd_a = idx_r + AB'(1);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IN && kw_en && cnt_r < n_lim) kept_mem[cnt_r[AB-1:0]] <= {kw_x, kw_y};
    else if (state_r == S_FIN && phase_r == 2'd2 && cnt_r < n_lim)
      kept_mem[cnt_r[AB-1:0]] <= {pend_x_r, pend_y_r};
    if (state_r == S_COPY && sub_r == 2'd1)
      sm_mem[idx_r] <= {kq[2*COORD_BITS-1:COORD_BITS], FRAC_BITS'(0),
                        kq[COORD_BITS-1:0], FRAC_BITS'(0)};
    else if (state_r == S_WB && c_r) sm_mem[idx_r] <= cur_upd;
  end

  always_comb begin
    cnt_a = cnt_r; ovf_a = ovf_r;
    if (kw_en) begin
      if (cnt_r < n_lim) cnt_a = cnt_r + CB'(1); else ovf_a = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IN; phase_r <= '0; cnt_r <= '0; ovf_r <= 1'b0;
      anc_x_r <= '0; anc_y_r <= '0; bas_x_r <= '0; bas_y_r <= '0;
      pend_x_r <= '0; pend_y_r <= '0; idx_r <= '0; sub_r <= '0;
      sweep_r <= '0; sum_r <= '0; c_r <= 1'b0; out_strobe <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      case (state_r)
        S_IN: if (acc) begin
          cnt_r <= cnt_a; ovf_r <= ovf_a;
          if (phase_r == 2'd0) begin
            anc_x_r <= $signed({1'b0, ix}); anc_y_r <= $signed({1'b0, iy});
            phase_r <= 2'd1;
          end else begin
            if (phase_r == 2'd1) begin
              bas_x_r <= dx; bas_y_r <= dy; phase_r <= 2'd2;
            end else if (cr != 0) begin
              anc_x_r <= $signed({1'b0, pend_x_r}); anc_y_r <= $signed({1'b0, pend_y_r});
              bas_x_r <= $signed({1'b0, ix}) - $signed({1'b0, pend_x_r});
              bas_y_r <= $signed({1'b0, iy}) - $signed({1'b0, pend_y_r});
            end
            pend_x_r <= ix; pend_y_r <= iy;
          end
          if (in_data.final_point) state_r <= S_FIN;
        end
        S_FIN: begin
          if (phase_r == 2'd2) begin
            if (cnt_r < n_lim) cnt_r <= cnt_r + CB'(1); else ovf_r <= 1'b1;
          end
          state_r <= S_COPY; idx_r <= '0; sub_r <= '0;
        end
        S_COPY: begin
          // sub 0: read issued, sub 1: data written
          if (sub_r == 2'd0) sub_r <= 2'd1;
          else begin
            sub_r <= 2'd0;
            if (CB'(idx_r) + CB'(1) >= cnt_r) begin
              sweep_r <= '0; sum_r <= '0;
              if (cnt_r > CB'(2)) begin
                state_r <= S_RD; idx_r <= AB'(1);
              end else begin
                state_r <= S_EMIT; idx_r <= '0;
              end
            end else idx_r <= idx_r + AB'(1);
          end
        end
        S_RD: begin
          // reads prev, cur, next in turn; each lands in rd_q and is taken on the next sub step
          sub_r <= sub_r + 2'd1;
          if (sub_r == 2'd1) prev_r <= rd_q;
          if (sub_r == 2'd2) cur_r <= rd_q;
          if (sub_r == 2'd3) begin
            nxt_r <= rd_q; sub_r <= '0; c_r <= 1'b0; state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_WB;
        S_WB: begin
          cur_r <= cur_upd;
          sum_r <= sum_w[SUM_BITS] ? '1 : sum_w[SUM_BITS-1:0];
          if (!c_r) begin
            c_r <= 1'b1; state_r <= S_MUL;
          end else begin
            c_r <= 1'b0;
            if (CB'(idx_r) + CB'(2) >= cnt_r) state_r <= S_CHK;
            else begin
              idx_r <= idx_r + AB'(1); state_r <= S_RD;
            end
          end
        end
        S_CHK: begin
          if (sum_r >= SUM_BITS'(cfg_r.stop_tolerance) && sweep_r + 12'd1 < lim) begin
            sweep_r <= sweep_r + 12'd1; sum_r <= '0; idx_r <= AB'(1); state_r <= S_RD;
          end else begin
            sweep_r <= sweep_r + 12'd1; idx_r <= '0; sub_r <= '0; state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (sub_r == 2'd0) sub_r <= 2'd1;
          else begin
            out_strobe <= 1'b1;
            out_data.sx <= OUT_BITS'(rd_q[2*QB-1:QB]);
            out_data.sy <= OUT_BITS'(rd_q[QB-1:0]);
            out_data.dropped <= ovf_r;
            out_data.final_result <= (CB'(idx_r) + CB'(1) >= cnt_r);
            if (CB'(idx_r) + CB'(1) >= cnt_r) begin
              state_r <= S_IN; phase_r <= '0; cnt_r <= '0; ovf_r <= 1'b0;
              anc_x_r <= '0; anc_y_r <= '0; bas_x_r <= '0; bas_y_r <= '0;
              pend_x_r <= '0; pend_y_r <= '0; sub_r <= '0;
            end else idx_r <= idx_r + AB'(1);
          end
        end
        default: state_r <= S_IN;
      endcase
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= n_lim)
    else $error("kept count past capacity");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy || $past(state_r) == S_EMIT)
    else $error("result outside emission");
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.final_result |-> !busy)
    else $error("busy on last beat");
  a_wb: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WB |-> $past(state_r) == S_MUL)
    else $error("write back without multiply stage");
endmodule
`default_nettype wire

/* hw/rtl/pss_update.sv */
`default_nettype none
// one coordinate update: old + round(wd*(orig-old)/256) + round(ws*lap/256), saturated
module pss_update import pss_pkg::*; #(
  parameter int QB = 17
) (
  input  wire logic          clk,
  input  wire logic [7:0]    wd,
  input  wire logic [7:0]    ws,
  input  wire logic [QB-1:0] old_v,
  input  wire logic [QB-1:0] orig_v,
  input  wire logic [QB-1:0] prev_v,
  input  wire logic [QB-1:0] next_v,
  output logic [QB-1:0]      new_v,
  output logic [QB:0]        diff_v
);
  localparam int W = QB + 12;
  logic signed [W-1:0] d_a, lap, pa, pb, old_s;
  logic signed [W-1:0] pa_r, pb_r, old_r;
  logic signed [W-1:0] nv;

  always_comb begin
    old_s = W'($signed({1'b0, old_v}));
    d_a   = W'($signed({1'b0, orig_v})) - old_s;
    lap   = W'($signed({1'b0, prev_v})) + W'($signed({1'b0, next_v})) - (old_s <<< 1);
    pa    = d_a * $signed({1'b0, wd});
    pb    = lap * $signed({1'b0, ws});
  end

  // register after the multipliers
  always_ff @(posedge clk) begin
    pa_r  <= pa;
    pb_r  <= pb;
    old_r <= old_s;
  end

  always_comb begin
    // floor((v+128)/256) is the required rounding
    nv = old_r + ((pa_r + W'(128)) >>> 8) + ((pb_r + W'(128)) >>> 8);
    if (nv < 0) new_v = '0;
    else if (nv > W'({QB{1'b1}})) new_v = '1;
    else new_v = nv[QB-1:0];
    diff_v = ({1'b0, new_v} >= old_r[QB:0]) ? {1'b0, new_v} - old_r[QB:0]
                                            : old_r[QB:0] - {1'b0, new_v};
  end
endmodule
`default_nettype wire
